// File: hdl/dlp_pkg.sv
// Package for the DAG longest-path core: sizes, widths and command codes.
// No dependencies.
`default_nettype none
package dlp_pkg;
   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int DW = 23;
   localparam int WW = 16;
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;
   localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DIST_MIN = {1'b1, {(DW-1){1'b0}}};
endpackage
`default_nettype wire

// File: hdl/dag_longest_path_core.sv
// Longest-path core over a weighted DAG held in on-chip memories.
// Depends on dlp_pkg.
//
// Use: pulse start with req_cmd/req_from_vertex/req_to_vertex/req_edge_weight
// while busy is low. An add-edge item is taken and returns nothing:
// busy stays low, so edges load back to back (the old tail is linked on the
// following cycle, with forwarding for two adds to one vertex in a row).
// A solve item raises busy from its accepting edge and walks the graph.
// Depth-first pass: each root index is tried in turn; each vertex is entered
// and left and each of its edges examined. Relaxation: each post-order vertex
// is popped; if reached, its head and best are read, each of its edges fetched
// and, if the edge's end is in use, best of that end read and updated. Output:
// one result per vertex in use, vertex 0 first, with a gap between results, each
// shown for one cycle with rsp_valid, rsp_last on the final one.
// Busy drops as the final result goes out, so the next item may be taken then.
// csr_we/csr_wdata set vertex_count (0 acts as 1, above 64 as 64) while idle.
// Synchronous reset empties the edge lists (valid bits on list heads) and
// sets vertex_count to 64. The receiver cannot stall results.
`default_nettype none
module dag_longest_path_core
   import dlp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_cmd,
   input  wire logic [VW-1:0]        req_from_vertex,
   input  wire logic [VW-1:0]        req_to_vertex,
   input  wire logic signed [WW-1:0] req_edge_weight,
   input  wire logic                 csr_we,
   input  wire logic [6:0]           csr_wdata,
   output logic                      rsp_valid,
   output logic [VW-1:0]             rsp_vertex,
   output logic signed [DW-1:0]      rsp_distance,
   output logic                      rsp_reachable,
   output logic                      rsp_last
);
   localparam logic [4:0] S_IDLE = 5'd0, S_ROOT = 5'd1, S_HEAD = 5'd2, S_TOP = 5'd3,
      S_EDGE = 5'd4, S_EFETCH = 5'd5, S_EUSE = 5'd6, S_HWAIT = 5'd7, S_RINIT = 5'd8,
      S_POP = 5'd9, S_RU = 5'd10, S_RHEAD = 5'd11, S_RE = 5'd12, S_RFETCH = 5'd13,
      S_RUSE = 5'd14, S_RD = 5'd15, S_RW = 5'd16, S_OREAD = 5'd17, S_OUT = 5'd18;

   // memories
   logic [VW-1:0]        m_dst  [MAX_EDGES];
   logic signed [WW-1:0] m_wt   [MAX_EDGES];
   logic [EW:0]          m_link [MAX_EDGES];
   logic [EW-1:0]        m_tail [MAX_VERTICES];
   logic [EW:0]          m_head [MAX_VERTICES];
   logic [VW-1:0]        m_wv   [MAX_VERTICES];
   logic [EW:0]          m_we   [MAX_VERTICES];
   logic [VW-1:0]        m_ord  [MAX_VERTICES];
   logic signed [DW-1:0] m_best [MAX_VERTICES];

   logic [MAX_VERTICES-1:0] head_ok_ff, seen_ff, reach_ff;
   logic [6:0]  vcount_ff;
   logic [EW:0] stored_ff;
   logic [4:0]  st_ff;
   logic [VW:0] sp_ff, op_ff, idx_ff;
   logic [VW-1:0] src_ff, cur_ff;
   logic [EW:0] e_ff;
   logic signed [DW-1:0] bu_ff, cand_ff;
   logic [VW-1:0] d_ff;

   // registered read data
   logic [VW-1:0] rd_dst_ff;
   logic signed [WW-1:0] rd_wt_ff;
   logic [EW:0] rd_link_ff, rd_head_ff, rd_we_ff;
   logic [EW-1:0] rd_tail_ff;
   logic [VW-1:0] rd_wv_ff, rd_ord_ff;
   logic signed [DW-1:0] rd_best_ff;
   logic head_v_ff;

   logic [VW:0] n;
   always_comb begin
      if (vcount_ff == 7'd0) n = (VW+1)'(1);
      else if (vcount_ff > 7'(MAX_VERTICES)) n = (VW+1)'(MAX_VERTICES);
      else n = vcount_ff[VW:0];
   end

   logic take, add_ok;
   assign busy = (st_ff != S_IDLE);
   assign take = start && !busy;
   assign add_ok = take && req_cmd == CMD_ADD && {1'b0, req_from_vertex} < n
      && {1'b0, req_to_vertex} < n && stored_ff < (EW+1)'(MAX_EDGES);

   // read addresses (combinational, data registered)
   logic [EW-1:0] ea;
   logic [VW-1:0] ha, sa, oa, ba;
   always_comb begin
      ea = e_ff[EW-1:0];
      ha = cur_ff;
      sa = sp_ff[VW-1:0] - 1'b1;
      oa = op_ff[VW-1:0] - 1'b1;
      ba = cur_ff;
      if (take) ha = req_from_vertex;
      if (st_ff == S_RD) ba = d_ff;
   end

   always_ff @(posedge clock) begin
      rd_dst_ff <= m_dst[ea]; rd_wt_ff <= m_wt[ea]; rd_link_ff <= m_link[ea];
      rd_head_ff <= m_head[ha]; rd_tail_ff <= m_tail[ha]; head_v_ff <= head_ok_ff[ha];
      rd_wv_ff <= m_wv[sa]; rd_we_ff <= m_we[sa]; rd_ord_ff <= m_ord[oa];
      rd_best_ff <= m_best[ba];
   end
   // head read gated by valid bits
   logic [EW:0] head_q;
   assign head_q = head_v_ff ? rd_head_ff : (EW+1)'(MAX_EDGES);

   // saturating add
   logic signed [DW:0] sum;
   logic signed [DW-1:0] sat;
   assign sum = (DW+1)'(bu_ff) + (DW+1)'(rd_wt_ff);
   always_comb begin
      if (sum > (DW+1)'(DIST_MAX)) sat = DIST_MAX;
      else if (sum < (DW+1)'(DIST_MIN)) sat = DIST_MIN;
      else sat = sum[DW-1:0];
   end

   logic add_pend_ff;
   logic [VW-1:0] add_a_ff;
   logic [EW-1:0] add_i_ff;
   logic add_had_ff, add_fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vcount_ff <= 7'd64; stored_ff <= '0; head_ok_ff <= '0;
         seen_ff <= '0; reach_ff <= '0; rsp_valid <= 1'b0; add_pend_ff <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_we) vcount_ff <= csr_wdata;
         add_pend_ff <= 1'b0;
         // second half of an add: link old tail, read when the add was taken
         if (add_pend_ff) begin
            if (add_had_ff) m_link[add_fwd_ff ? add_i_ff - 1'b1 : rd_tail_ff] <= {1'b0, add_i_ff};
            m_tail[add_a_ff] <= add_i_ff;
         end
         case (st_ff)
            S_IDLE: begin
               if (add_ok) begin
                  m_dst[stored_ff[EW-1:0]] <= req_to_vertex;
                  m_wt[stored_ff[EW-1:0]] <= req_edge_weight;
                  m_link[stored_ff[EW-1:0]] <= (EW+1)'(MAX_EDGES);
                  if (!head_ok_ff[req_from_vertex]) begin
                     head_ok_ff[req_from_vertex] <= 1'b1;
                     m_head[req_from_vertex] <= stored_ff;
                  end
                  add_had_ff <= head_ok_ff[req_from_vertex];
                  // back-to-back add to same vertex: tail not yet written
                  add_fwd_ff <= add_pend_ff && add_a_ff == req_from_vertex;
                  add_pend_ff <= 1'b1;
                  add_a_ff <= req_from_vertex;
                  add_i_ff <= stored_ff[EW-1:0];
                  stored_ff <= stored_ff + 1'b1;
               end else if (take && req_cmd == CMD_SOLVE) begin
                  src_ff <= req_from_vertex; seen_ff <= '0; reach_ff <= '0;
                  op_ff <= '0; idx_ff <= '0; cur_ff <= '0; st_ff <= S_ROOT;
               end
            end
            S_ROOT: begin // head read of cur_ff issued here
               if (idx_ff >= n) begin
                  st_ff <= S_RINIT;
               end else if (seen_ff[idx_ff[VW-1:0]]) begin
                  idx_ff <= idx_ff + 1'b1; cur_ff <= idx_ff[VW-1:0] + 1'b1;
               end else begin
                  seen_ff[idx_ff[VW-1:0]] <= 1'b1; sp_ff <= '0; st_ff <= S_HEAD;
               end
            end
            S_HEAD: begin // push frame
               m_wv[sp_ff[VW-1:0]] <= cur_ff; m_we[sp_ff[VW-1:0]] <= head_q;
               sp_ff <= sp_ff + 1'b1; st_ff <= S_TOP;
            end
            S_TOP: st_ff <= S_EDGE; // stack top read in flight
            S_EDGE: begin
               if (sp_ff == '0) begin
                  idx_ff <= idx_ff + 1'b1; cur_ff <= idx_ff[VW-1:0] + 1'b1;
                  st_ff <= S_ROOT;
               end else if (rd_we_ff >= (EW+1)'(MAX_EDGES)) begin
                  if (op_ff < (VW+1)'(MAX_VERTICES)) begin
                     m_ord[op_ff[VW-1:0]] <= rd_wv_ff; op_ff <= op_ff + 1'b1;
                  end
                  sp_ff <= sp_ff - 1'b1; st_ff <= S_TOP;
               end else begin
                  e_ff <= rd_we_ff; st_ff <= S_EFETCH;
               end
            end
            S_EFETCH: st_ff <= S_EUSE;
            S_EUSE: begin
               m_we[sa] <= rd_link_ff;
               if ({1'b0, rd_dst_ff} < n && !seen_ff[rd_dst_ff]
                   && sp_ff < (VW+1)'(MAX_VERTICES)) begin
                  seen_ff[rd_dst_ff] <= 1'b1; cur_ff <= rd_dst_ff; st_ff <= S_HWAIT;
               end else st_ff <= S_TOP;
            end
            S_HWAIT: st_ff <= S_HEAD; // head read of new vertex
            S_RINIT: begin
               if ({1'b0, src_ff} < n) begin
                  reach_ff[src_ff] <= 1'b1; m_best[src_ff] <= '0;
                  st_ff <= S_POP;
               end else begin
                  idx_ff <= '0; cur_ff <= '0; st_ff <= S_OREAD;
               end
            end
            S_POP: begin // ord read issued with op-1
               if (op_ff == '0) begin
                  idx_ff <= '0; cur_ff <= '0; st_ff <= S_OREAD;
               end else st_ff <= S_RU;
            end
            S_RU: begin
               op_ff <= op_ff - 1'b1;
               if (reach_ff[rd_ord_ff]) begin
                  cur_ff <= rd_ord_ff; st_ff <= S_RHEAD;
               end else st_ff <= S_POP;
            end
            S_RHEAD: st_ff <= S_RE; // head and best of u in flight
            S_RE: begin
               bu_ff <= rd_best_ff; e_ff <= head_q;
               if (head_q >= (EW+1)'(MAX_EDGES)) st_ff <= S_POP;
               else st_ff <= S_RFETCH;
            end
            S_RFETCH: st_ff <= S_RUSE;
            S_RUSE: begin
               d_ff <= rd_dst_ff; cand_ff <= sat; e_ff <= rd_link_ff;
               if ({1'b0, rd_dst_ff} < n) st_ff <= S_RD;
               else if (rd_link_ff >= (EW+1)'(MAX_EDGES)) st_ff <= S_POP;
               else st_ff <= S_RFETCH;
            end
            S_RD: st_ff <= S_RW; // best[d] read in flight
            S_RW: begin
               if (!reach_ff[d_ff] || rd_best_ff < cand_ff) begin
                  m_best[d_ff] <= cand_ff; reach_ff[d_ff] <= 1'b1;
                  // self-loop: later edges of u see the new distance
                  if (d_ff == cur_ff) bu_ff <= cand_ff;
               end
               st_ff <= (e_ff >= (EW+1)'(MAX_EDGES)) ? S_POP : S_RFETCH;
            end
            S_OREAD: st_ff <= S_OUT;
            S_OUT: begin
               rsp_valid <= 1'b1; rsp_vertex <= idx_ff[VW-1:0];
               rsp_reachable <= reach_ff[idx_ff[VW-1:0]];
               rsp_distance <= reach_ff[idx_ff[VW-1:0]] ? rd_best_ff : '0;
               rsp_last <= (idx_ff + 1'b1 == n);
               if (idx_ff + 1'b1 == n) st_ff <= S_IDLE;
               else begin
                  idx_ff <= idx_ff + 1'b1; cur_ff <= idx_ff[VW-1:0] + 1'b1;
                  st_ff <= S_OREAD;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> !rsp_valid);
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy);
   a_unreached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_distance == '0);
   a_vertex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_vertex} < n);
   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= (EW+1)'(MAX_EDGES));
`endif

endmodule
`default_nettype wire

// File: verif/dlp_checker.sv
// Checker for the DAG longest-path core: tracks the edge table and vertex count,
// predicts the result stream of every solve and compares it field by field.
// Depends on dlp_pkg.
`timescale 1ns / 100ps
module dlp_checker
   import dlp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic                 req_cmd,
   input  wire logic [VW-1:0]        req_from_vertex,
   input  wire logic [VW-1:0]        req_to_vertex,
   input  wire logic signed [WW-1:0] req_edge_weight,
   input  wire logic                 csr_we,
   input  wire logic [6:0]           csr_wdata,
   input  wire logic                 rsp_valid,
   input  wire logic [VW-1:0]        rsp_vertex,
   input  wire logic signed [DW-1:0] rsp_distance,
   input  wire logic                 rsp_reachable,
   input  wire logic                 rsp_last,
   output int                        fail_count,
   output int                        results_owed
);
   localparam int NO_EDGE = MAX_EDGES;
   localparam int OWED_DEPTH = 2 * MAX_VERTICES;

   typedef struct {
      logic [VW-1:0]        vertex;
      logic signed [DW-1:0] distance;
      logic                 reachable;
      logic                 last;
   } vertex_result_type;

   logic [6:0]           count_reg;
   logic [VW-1:0]        tbl_dst [MAX_EDGES];
   logic signed [WW-1:0] tbl_wt [MAX_EDGES];
   int                   tbl_next [MAX_EDGES];
   int                   tbl_used;
   int                   adj_head [MAX_VERTICES];
   int                   adj_tail [MAX_VERTICES];
   vertex_result_type    owed_buf [OWED_DEPTH];
   int                   owed_wr;
   int                   owed_rd;

   function automatic int live_vertices();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_VERTICES) return MAX_VERTICES;
      return int'(count_reg);
   endfunction

   function automatic logic signed [DW-1:0] clamp_sum(int s);
      if (s > int'(DIST_MAX)) return DIST_MAX;
      if (s < int'(DIST_MIN)) return DIST_MIN;
      return DW'(s);
   endfunction

   task automatic owe_result(vertex_result_type r);
      owed_buf[owed_wr % OWED_DEPTH] = r;
      owed_wr++;
   endtask

   task automatic store_edge(int a, int b, logic signed [WW-1:0] w);
      int n;
      n = live_vertices();
      if (a >= n || b >= n || tbl_used >= MAX_EDGES) return;
      tbl_dst[tbl_used] = VW'(b);
      tbl_wt[tbl_used] = w;
      tbl_next[tbl_used] = NO_EDGE;
      if (adj_head[a] == NO_EDGE) adj_head[a] = tbl_used;
      else tbl_next[adj_tail[a]] = tbl_used;
      adj_tail[a] = tbl_used;
      tbl_used++;
   endtask

   task automatic predict_paths(int src);
      int n, sp, top, e, d, u, nord;
      bit seen [MAX_VERTICES];
      bit reach [MAX_VERTICES];
      int lengths [MAX_VERTICES];
      int frame_v [MAX_VERTICES];
      int frame_e [MAX_VERTICES];
      int post [MAX_VERTICES];
      vertex_result_type r;
      n = live_vertices();
      nord = 0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         seen[i] = 0;
         reach[i] = 0;
         lengths[i] = 0;
      end
      // iterative DFS post-order, roots ascending
      for (int i = 0; i < n; i++) begin
         if (seen[i]) continue;
         seen[i] = 1;
         frame_v[0] = i;
         frame_e[0] = adj_head[i];
         sp = 1;
         while (sp > 0) begin
            top = sp - 1;
            e = frame_e[top];
            if (e >= MAX_EDGES) begin
               if (nord < MAX_VERTICES) begin
                  post[nord] = frame_v[top];
                  nord++;
               end
               sp--;
            end else begin
               d = tbl_dst[e];
               frame_e[top] = tbl_next[e];
               if (d < n && !seen[d] && sp < MAX_VERTICES) begin
                  seen[d] = 1;
                  frame_v[sp] = d;
                  frame_e[sp] = adj_head[d];
                  sp++;
               end
            end
         end
      end
      if (src < n) begin
         reach[src] = 1;
         while (nord > 0) begin
            nord--;
            u = post[nord];
            if (!reach[u]) continue;
            for (e = adj_head[u]; e < MAX_EDGES; e = tbl_next[e]) begin
               int cand;
               d = tbl_dst[e];
               if (d >= n) continue;
               cand = int'(clamp_sum(lengths[u] + int'(tbl_wt[e])));
               if (!reach[d] || lengths[d] < cand) begin
                  lengths[d] = cand;
                  reach[d] = 1;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         r.vertex = VW'(i);
         r.distance = reach[i] ? DW'(lengths[i]) : '0;
         r.reachable = reach[i];
         r.last = (i == n - 1);
         owe_result(r);
      end
   endtask

   always @(posedge clock) begin
      vertex_result_type want;
      if (reset) begin
         count_reg = 7'd64;
         tbl_used = 0;
         for (int i = 0; i < MAX_VERTICES; i++) adj_head[i] = NO_EDGE;
         owed_wr = 0;
         owed_rd = 0;
         fail_count = 0;
      end else begin
         if (csr_we) count_reg = csr_wdata;
         if (start && !busy) begin
            if (req_cmd == CMD_ADD)
               store_edge(req_from_vertex, req_to_vertex, req_edge_weight);
            else
               predict_paths(req_from_vertex);
         end
         if (rsp_valid) begin
            if (owed_wr == owed_rd) begin
               $display("%0t: unexpected result vertex %0d dist %0d reach %0b last %0b",
                        $time, rsp_vertex, rsp_distance, rsp_reachable, rsp_last);
               fail_count++;
            end else begin
               want = owed_buf[owed_rd % OWED_DEPTH];
               owed_rd++;
               if (rsp_vertex !== want.vertex || rsp_distance !== want.distance ||
                   rsp_reachable !== want.reachable || rsp_last !== want.last) begin
                  $display({"%0t: mismatch expected v %0d d %0d r %0b l %0b,",
                            " got v %0d d %0d r %0b l %0b"},
                           $time, want.vertex, want.distance, want.reachable, want.last,
                           rsp_vertex, rsp_distance, rsp_reachable, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      results_owed <= owed_wr - owed_rd;
   end
endmodule

// File: verif/dag_longest_path_core_tb.sv
// Testbench top for dag_longest_path_core: drives edge loads, solves and
// vertex-count writes; dlp_checker does the prediction. Depends on dlp_pkg.
`timescale 1ns / 100ps
module dag_longest_path_core_tb;
   import dlp_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_cmd;
   logic [VW-1:0]        req_from_vertex;
   logic [VW-1:0]        req_to_vertex;
   logic signed [WW-1:0] req_edge_weight;
   logic                 csr_we;
   logic [6:0]           csr_wdata;
   logic                 rsp_valid;
   logic [VW-1:0]        rsp_vertex;
   logic signed [DW-1:0] rsp_distance;
   logic                 rsp_reachable;
   logic                 rsp_last;
   int                   fail_count;
   int                   results_owed;

   int  live_n = 64;
   bit  no_gaps = 0;

   dag_longest_path_core u_top (.*);

   dlp_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic issue(logic cmd, int a, int b, logic signed [WW-1:0] w);
      int gap;
      bit taken;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_cmd <= cmd;
      req_from_vertex <= VW'(a);
      req_to_vertex <= VW'(b);
      req_edge_weight <= w;
      // busy only moves at rising edges, so the falling-edge value holds at the next one
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (busy || results_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_count(logic [6:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      live_n = (v == 0) ? 1 : (v > MAX_VERTICES) ? MAX_VERTICES : int'(v);
   endtask

   // mostly forward edges (acyclic) with random weights, some raw noise
   task automatic random_item();
      int a, b, pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         issue(CMD_SOLVE, (pick < 17) ? $urandom_range(0, live_n - 1) : $urandom_range(0, 63),
               $urandom_range(0, 63), WW'($urandom));
      else if (pick < 30 || live_n < 2)
         issue(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63), WW'($urandom));
      else begin
         a = $urandom_range(0, live_n - 2);
         b = $urandom_range(a + 1, live_n - 1);
         issue(CMD_ADD, a, b, WW'($urandom));
      end
   endtask

   initial begin
      logic [6:0] counts [6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd40, 7'd12};
      reset = 1;
      start = 0;
      req_cmd = CMD_ADD;
      req_from_vertex = '0;
      req_to_vertex = '0;
      req_edge_weight = '0;
      csr_we = 0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, ignored endpoints, unreached and out-of-range sources
      set_count(7'd8);
      issue(CMD_SOLVE, 0, 0, 0);
      issue(CMD_ADD, 0, 1, 16'sh7FFF);
      issue(CMD_ADD, 1, 2, 16'sh7FFF);
      issue(CMD_ADD, 0, 2, 16'sh8000);
      issue(CMD_ADD, 2, 3, -16'sd1);
      issue(CMD_ADD, 5, 6, 16'sd100);
      issue(CMD_ADD, 5, 7, 16'sd5);
      issue(CMD_ADD, 3, 8, 16'sd9);
      issue(CMD_ADD, 63, 0, 16'sd9);
      issue(CMD_SOLVE, 0, 0, 0);
      issue(CMD_SOLVE, 5, 0, 0);
      issue(CMD_SOLVE, 7, 0, 0);
      issue(CMD_SOLVE, 63, 63, 16'shFFFF);
      set_count(7'd6);
      issue(CMD_SOLVE, 5, 0, 0);
      issue(CMD_ADD, 3, 0, 16'sd7);
      issue(CMD_SOLVE, 0, 0, 0);
      issue(CMD_SOLVE, 3, 0, 0);

      for (int p = 0; p < 6; p++) begin
         set_count(counts[p]);
         for (int k = 0; k < 27; k++) begin
            if (k % 10 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            random_item();
         end
         no_gaps = 0;
      end

      set_count(7'd64);
      issue(CMD_SOLVE, 0, 0, 0);
      issue(CMD_SOLVE, $urandom_range(0, 63), 0, 0);

      drain();
      if (fail_count == 0 && results_owed == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
